// ----- hw/rtl/asc_pkg.sv -----
`default_nettype none
// ============================================================================
// asc_pkg
// Shared types, widths, codes and the arctangent table for the soft-clip unit.
// ============================================================================
package asc_pkg;

    // Sample format, Q1.23.
    localparam int SAMPLE_BITS = 24;

    // Internal widths.
    localparam int CORD_W  = 44;  // CORDIC x and y, Q.30
    localparam int ANG_W   = 36;  // angles, Q2.30 with headroom
    localparam int DIVN_W  = 64;  // divider dividend
    localparam int DIVD_W  = 44;  // divider divisor
    localparam int DIVQ_W  = 33;  // divider quotient
    localparam int MUL_W   = 34;  // multiplier operand
    localparam int PROD_W  = 68;  // multiplier product
    localparam int ACC_W   = 40;  // high-pass store
    localparam int Y_W     = 28;  // soft-clip result, up to +-8.0
    localparam int HP_W    = 26;  // high-pass output, up to +-2.0
    localparam int DRV_W   = 32;  // drive and its arctangent
    localparam int ITER_W  = 5;   // CORDIC step index
    localparam int KNOB_W  = 17;
    localparam int POLE_W  = 25;
    localparam int IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] REG_MIX   = 3'd0;
    localparam logic [IDX_W-1:0] REG_DC    = 3'd1;
    localparam logic [IDX_W-1:0] REG_DRIVE = 3'd2;
    localparam logic [IDX_W-1:0] REG_GAIN  = 3'd3;
    localparam logic [IDX_W-1:0] REG_POLE  = 3'd4;

    localparam logic [KNOB_W-1:0] UNITY_Q16 = 17'h10000;
    localparam logic [POLE_W-1:0] POLE_ONE  = 25'h1000000;
    localparam logic [POLE_W-1:0] POLE_RST  = 25'd16776167;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE, ST_DRV_SQ, ST_DRV_RND, ST_SC_MUL, ST_SC_Z, ST_CORDIC,
        ST_ATAN_DIV, ST_ATAN_WAIT, ST_ATAN_RES, ST_DRV_NORM, ST_SC_DIV,
        ST_SC_WAIT, ST_SC_RES, ST_PASS, ST_HP_LO, ST_HP_HI, ST_HP_RND,
        ST_HP_W, ST_HP_D, ST_GAIN, ST_CLIP, ST_MIX_A, ST_MIX_B, ST_MIX_SUM,
        ST_OUT
    } state_t;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD_X, OP_DRV_SQ, OP_DRV_RND, OP_SC_MUL, OP_SC_Z,
        OP_COR_STEP, OP_ATAN_DIV, OP_ATAN_RES, OP_DRV_NORM, OP_SC_DIV,
        OP_SC_RES, OP_PASS, OP_HP_LO, OP_HP_HI, OP_HP_RND, OP_HP_W, OP_HP_D,
        OP_GAIN, OP_CLIP, OP_MIX_A, OP_MIX_B, OP_MIX_SUM
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic drive_zero;
        logic div_busy;
    } status_t;

    // atan(2^-i) in Q2.30.
    function automatic logic [30:0] atan_tab(input logic [ITER_W-1:0] i);
        logic [30:0] v;
        begin
            case (i)
                5'd0:  v = 31'h3243F6A8;
                5'd1:  v = 31'h1DAC6705;
                5'd2:  v = 31'h0FADBAFC;
                5'd3:  v = 31'h07F56EA6;
                5'd4:  v = 31'h03FEAB76;
                5'd5:  v = 31'h01FFD55B;
                5'd6:  v = 31'h00FFFAAA;
                5'd7:  v = 31'h007FFF55;
                5'd8:  v = 31'h003FFFEA;
                5'd9:  v = 31'h001FFFFD;
                5'd10: v = 31'h000FFFFF;
                5'd11: v = 31'h0007FFFF;
                5'd12: v = 31'h0003FFFF;
                5'd13: v = 31'h0001FFFF;
                5'd14: v = 31'h0000FFFF;
                5'd15: v = 31'h00007FFF;
                5'd16: v = 31'h00003FFF;
                5'd17: v = 31'h00001FFF;
                5'd18: v = 31'h00000FFF;
                5'd19: v = 31'h000007FF;
                5'd20: v = 31'h000003FF;
                5'd21: v = 31'h000001FF;
                5'd22: v = 31'h000000FF;
                5'd23: v = 31'h0000007F;
                5'd24: v = 31'h0000003F;
                5'd25: v = 31'h0000001F;
                5'd26: v = 31'h0000000F;
                5'd27: v = 31'h00000008;
                5'd28: v = 31'h00000004;
                5'd29: v = 31'h00000002;
                5'd30: v = 31'h00000001;
                default: v = 31'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/atan_softclip_distortion_unit.sv -----
`default_nettype none
// ============================================================================
// atan_softclip_distortion_unit
// Arctangent soft clip, DC-blocking high-pass, gain, hard clip and wet/dry mix.
// ============================================================================
// With nonzero drive a sample passes through the CORDIC loop and two divisions on
// the shared divider, which dominate its latency; with zero drive it takes the
// pass path. One sample is processed at a time, so a new sample is not accepted
// until the last one has been loaded into the output register. After a write to
// soft_drive_knob, s_tready stays low until the drive update has run. Reset
// clears the drive, its arctangent and the high-pass store; no clearing pass.
module atan_softclip_distortion_unit
    import asc_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_tdata,   // [23:0] sample_in
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [SAMPLE_BITS-1:0]      m_tdata,   // [23:0] sample_out
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [4:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [KNOB_W-1:0] mix_reg, knob_reg, gain_reg;
    logic [15:0]       dc_reg;
    logic [POLE_W-1:0] pole_reg;
    logic              wr_en;
    logic [IDX_W-1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_reg  <= UNITY_Q16;
            dc_reg   <= '0;
            knob_reg <= '0;
            gain_reg <= '0;
            pole_reg <= POLE_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MIX:   mix_reg  <= pwdata[KNOB_W-1:0];
                REG_DC:    dc_reg   <= pwdata[15:0];
                REG_DRIVE: knob_reg <= pwdata[KNOB_W-1:0];
                REG_GAIN:  gain_reg <= pwdata[KNOB_W-1:0];
                REG_POLE:  pole_reg <= pwdata[POLE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (idx)
            REG_MIX:   prdata = {15'b0, mix_reg};
            REG_DC:    prdata = {{16{dc_reg[15]}}, dc_reg};
            REG_DRIVE: prdata = {15'b0, knob_reg};
            REG_GAIN:  prdata = {15'b0, gain_reg};
            REG_POLE:  prdata = {7'b0, pole_reg};
            default:   prdata = '0;
        endcase
    end

    logic    knob_wr;
    cmd_t    cmd;
    status_t status;
    logic    out_free;
    logic    m_tvalid_reg;
    logic [SAMPLE_BITS-1:0] m_tdata_reg, result;

    assign knob_wr  = wr_en && (idx == REG_DRIVE);
    assign out_free = !m_tvalid_reg || m_tready;

    asc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .knob_wr  (knob_wr),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    asc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sample_in       (s_tdata),
        .mix_amount      (mix_reg),
        .dc_offset       (dc_reg),
        .soft_drive_knob (knob_reg),
        .clip_gain_knob  (gain_reg),
        .hpf_pole        (pole_reg),
        .status          (status),
        .sample_out      (result)
    );

    // Output register; a result transaction waits here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/asc_div.sv -----
`default_nettype none
// ============================================================================
// asc_div
// Restoring divider, one quotient bit per cycle, shared by both quotients.
// ============================================================================
module asc_div
    import asc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DIVN_W-1:0] num,
    input  wire logic [DIVD_W-1:0] den,
    output logic      [DIVQ_W-1:0] quo,
    output logic                   ovf,
    output logic                   busy
);

    localparam int CNT_W = $clog2(DIVQ_W + 1);
    localparam int TOP_W = DIVN_W - DIVQ_W;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVQ_W-1:0] quo_reg, quo_next;
    logic [DIVD_W-1:0] den_reg, den_next;
    logic              ovf_reg, ovf_next;
    logic [DIVD_W:0]   trial;
    logic [DIVD_W-1:0] top_part;

    // Upper dividend bits form the first partial remainder.
    assign top_part = {{(DIVD_W-TOP_W){1'b0}}, num[DIVN_W-1:DIVQ_W]};
    assign trial    = {rem_reg, quo_reg[DIVQ_W-1]};

    // One compare and subtract per cycle.
    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        ovf_next = ovf_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVQ_W);
            rem_next = top_part;
            quo_next = num[DIVQ_W-1:0];
            den_next = den;
            ovf_next = (top_part >= den);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DIVD_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIVQ_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVD_W-1:0];
                quo_next = {quo_reg[DIVQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        ovf_reg <= ovf_next;
    end

    assign quo  = quo_reg;
    assign ovf  = ovf_reg;
    assign busy = (cnt_reg != '0);

endmodule
`default_nettype wire

// ----- hw/rtl/asc_datapath.sv -----
`default_nettype none
// ============================================================================
// asc_datapath
// Shared multiplier, CORDIC registers, divider and the filter, gain and mix.
// ============================================================================
module asc_datapath
    import asc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    input  wire logic [SAMPLE_BITS-1:0] sample_in,
    input  wire logic [KNOB_W-1:0]      mix_amount,
    input  wire logic [15:0]            dc_offset,
    input  wire logic [KNOB_W-1:0]      soft_drive_knob,
    input  wire logic [KNOB_W-1:0]      clip_gain_knob,
    input  wire logic [POLE_W-1:0]      hpf_pole,
    output status_t                     status,
    output logic [SAMPLE_BITS-1:0]      sample_out
);

    localparam logic signed [CORD_W-1:0] Y_LIM   = 44'sh0_0100_0000_00;
    localparam logic signed [CORD_W-1:0] X_INIT  = 44'sh0_0000_4000_0000;
    localparam logic signed [ACC_W+1:0]  ACC_MAX = 42'sh0_7F_FFFF_FFFF;
    localparam logic signed [ACC_W+1:0]  ACC_MIN = -42'sh0_80_0000_0000;
    localparam logic signed [ACC_W:0]    HP_LIM  = 41'sd16777216;
    localparam logic signed [51:0]       T_MAX   = 52'sd8388607;
    localparam logic signed [51:0]       T_MIN   = -52'sd8388608;
    localparam logic [DIVQ_W-1:0]        SC_LIM  = 33'd67108864;

    // Registers.
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic [DRV_W-1:0]              drive_reg, norm_reg;
    logic signed [CORD_W-1:0]      cx_reg, cy_reg;
    logic signed [ANG_W-1:0]       ca_reg, ang_reg;
    logic                          neg_reg;
    logic signed [Y_W-1:0]         y_reg;
    logic signed [ACC_W-1:0]       acc_reg, w_reg;
    logic signed [ACC_W:0]         prnd_reg;
    logic signed [HP_W-1:0]        hp_reg;
    logic signed [SAMPLE_BITS-1:0] t_reg, res_reg;
    logic signed [PROD_W-1:0]      mult_reg, part_reg;

    // Capped configuration values and constant products.
    logic [KNOB_W-1:0] knob_c, gain_c, mix_c, mix_inv;
    logic [POLE_W-1:0] pole_c;
    logic [21:0]       k30, gain_g;

    assign knob_c  = (soft_drive_knob > UNITY_Q16) ? UNITY_Q16 : soft_drive_knob;
    assign gain_c  = (clip_gain_knob > UNITY_Q16) ? UNITY_Q16 : clip_gain_knob;
    assign mix_c   = (mix_amount > UNITY_Q16) ? UNITY_Q16 : mix_amount;
    assign mix_inv = UNITY_Q16 - mix_c;
    assign pole_c  = (hpf_pole > POLE_ONE) ? POLE_ONE : hpf_pole;
    assign k30     = ({5'b0, knob_c} << 5) - ({5'b0, knob_c} << 1);
    assign gain_g  = {5'b0, UNITY_Q16} + ({5'b0, gain_c} << 5) - ({5'b0, gain_c} << 1);

    // Shared multiplier operand selection.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_DRV_SQ:
            begin
                mul_a = $signed({12'b0, k30});
                mul_b = $signed({12'b0, k30});
            end
            OP_SC_MUL:
            begin
                mul_a = MUL_W'(x_reg);
                mul_b = $signed({2'b0, drive_reg});
            end
            OP_HP_LO:
            begin
                mul_a = $signed({9'b0, pole_c});
                mul_b = $signed({14'b0, acc_reg[19:0]});
            end
            OP_HP_HI:
            begin
                mul_a = $signed({9'b0, pole_c});
                mul_b = MUL_W'($signed(acc_reg[ACC_W-1:20]));
            end
            OP_GAIN:
            begin
                mul_a = MUL_W'(hp_reg);
                mul_b = $signed({12'b0, gain_g});
            end
            OP_MIX_A:
            begin
                mul_a = $signed({17'b0, mix_c});
                mul_b = MUL_W'(t_reg);
            end
            OP_MIX_B:
            begin
                mul_a = $signed({17'b0, mix_inv});
                mul_b = MUL_W'(x_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Drive from the squared knob, rounded to Q10.22.
    logic [42:0]      drv_sum;
    logic [DRV_W-1:0] drv_new;

    assign drv_sum = {1'b0, mult_reg[41:0]} + 43'd512;
    assign drv_new = drv_sum[41:10];

    // Arctangent argument for a sample.
    logic signed [PROD_W-1:0] sc_sum;
    logic signed [CORD_W-1:0] sc_z;

    assign sc_sum = mult_reg + PROD_W'(16384);
    assign sc_z   = CORD_W'($signed(dc_offset)) * CORD_W'(32768)
                  + $signed(sc_sum[CORD_W+14:15]);

    // One CORDIC rotation.
    logic signed [CORD_W-1:0] cor_dx, cor_dy;
    logic signed [ANG_W-1:0]  cor_ang;

    assign cor_dx  = cy_reg >>> cmd.iter;
    assign cor_dy  = cx_reg >>> cmd.iter;
    assign cor_ang = $signed({5'b0, atan_tab(cmd.iter)});

    // Divider operands: CORDIC residual over x, or angle over atan(drive).
    logic signed [CORD_W-1:0] y_abs;
    logic [32:0]              y_mag;
    logic signed [ANG_W-1:0]  ang_abs;
    logic                     div_start;
    logic [DIVN_W-1:0]        div_num;
    logic [DIVD_W-1:0]        div_den;
    logic [DIVQ_W-1:0]        div_quo;
    logic                     div_ovf, div_busy;

    assign y_abs   = cy_reg[CORD_W-1] ? -cy_reg : cy_reg;
    assign y_mag   = (y_abs > Y_LIM) ? 33'h1_0000_0000 : y_abs[32:0];
    assign ang_abs = ang_reg[ANG_W-1] ? -ang_reg : ang_reg;

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (cmd.op)
            OP_ATAN_DIV:
            begin
                div_start = 1'b1;
                div_num   = {1'b0, y_mag, 30'b0};
                div_den   = cx_reg;
            end
            OP_SC_DIV:
            begin
                div_start = 1'b1;
                div_num   = {6'b0, ang_abs[34:0], 23'b0};
                div_den   = {12'b0, norm_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    asc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .ovf   (div_ovf),
        .busy  (div_busy)
    );

    // Signed quotient, angle and soft-clip results.
    logic signed [ANG_W-1:0] q_ext;
    logic                    sc_big;
    logic [26:0]             sc_mag;

    assign q_ext  = $signed({3'b0, div_quo});
    assign sc_big = div_ovf || (div_quo > SC_LIM);
    assign sc_mag = sc_big ? 27'h4000000 : div_quo[26:0];

    // High-pass sums.
    logic signed [65:0]      hp_hi, hp_lo, hp_sum;
    logic signed [ACC_W+1:0] w_sum;
    logic signed [ACC_W:0]   d_sum;

    assign hp_hi  = $signed({{20{mult_reg[45]}}, mult_reg[45:0]}) <<< 20;
    assign hp_lo  = $signed({21'b0, part_reg[44:0]});
    assign hp_sum = hp_hi + hp_lo + 66'sd8388608;
    assign w_sum  = (ACC_W+2)'(y_reg) + (ACC_W+2)'(prnd_reg);
    assign d_sum  = (ACC_W+1)'(w_reg) - (ACC_W+1)'(acc_reg);

    // Gain rounding and mix.
    logic signed [PROD_W-1:0] g_sum, m_sum;
    logic signed [51:0]       g_sh;

    assign g_sum = mult_reg + PROD_W'(32768);
    assign g_sh  = g_sum[67:16];
    assign m_sum = part_reg + mult_reg + PROD_W'(32768);

    // Control state of the datapath: drive, its arctangent and the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= '0;
            norm_reg  <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_DRV_RND:
                begin
                    drive_reg <= drv_new;
                    if (drv_new == '0)
                    begin
                        norm_reg <= '0;
                    end
                end
                OP_DRV_NORM:
                begin
                    norm_reg <= (ang_reg < 36'sd1) ? 32'd1 : ang_reg[DRV_W-1:0];
                end
                OP_HP_D:
                begin
                    acc_reg <= w_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        mult_reg <= mul_p;
        case (cmd.op)
            OP_LOAD_X:
            begin
                x_reg <= sample_in;
            end
            OP_DRV_RND:
            begin
                cx_reg <= X_INIT;
                cy_reg <= $signed({4'b0, drv_new, 8'b0});
                ca_reg <= '0;
            end
            OP_SC_Z:
            begin
                cx_reg <= X_INIT;
                cy_reg <= sc_z;
                ca_reg <= '0;
            end
            OP_COR_STEP:
            begin
                if (!cy_reg[CORD_W-1])
                begin
                    cx_reg <= cx_reg + cor_dx;
                    cy_reg <= cy_reg - cor_dy;
                    ca_reg <= ca_reg + cor_ang;
                end
                else
                begin
                    cx_reg <= cx_reg - cor_dx;
                    cy_reg <= cy_reg + cor_dy;
                    ca_reg <= ca_reg - cor_ang;
                end
            end
            OP_ATAN_DIV:
            begin
                neg_reg <= cy_reg[CORD_W-1];
            end
            OP_ATAN_RES:
            begin
                ang_reg <= neg_reg ? (ca_reg - q_ext) : (ca_reg + q_ext);
            end
            OP_SC_DIV:
            begin
                neg_reg <= ang_reg[ANG_W-1];
            end
            OP_SC_RES:
            begin
                y_reg <= neg_reg ? -$signed({1'b0, sc_mag}) : $signed({1'b0, sc_mag});
            end
            OP_PASS:
            begin
                y_reg <= Y_W'(x_reg);
            end
            OP_HP_HI:
            begin
                part_reg <= mult_reg;
            end
            OP_HP_RND:
            begin
                prnd_reg <= hp_sum[64:24];
            end
            OP_HP_W:
            begin
                if (w_sum > ACC_MAX)
                begin
                    w_reg <= ACC_MAX[ACC_W-1:0];
                end
                else if (w_sum < ACC_MIN)
                begin
                    w_reg <= ACC_MIN[ACC_W-1:0];
                end
                else
                begin
                    w_reg <= w_sum[ACC_W-1:0];
                end
            end
            OP_HP_D:
            begin
                if (d_sum > HP_LIM)
                begin
                    hp_reg <= HP_LIM[HP_W-1:0];
                end
                else if (d_sum < -HP_LIM)
                begin
                    hp_reg <= HP_W'(-HP_LIM);
                end
                else
                begin
                    hp_reg <= d_sum[HP_W-1:0];
                end
            end
            OP_CLIP:
            begin
                if (g_sh > T_MAX)
                begin
                    t_reg <= T_MAX[SAMPLE_BITS-1:0];
                end
                else if (g_sh < T_MIN)
                begin
                    t_reg <= T_MIN[SAMPLE_BITS-1:0];
                end
                else
                begin
                    t_reg <= g_sh[SAMPLE_BITS-1:0];
                end
            end
            OP_MIX_B:
            begin
                part_reg <= mult_reg;
            end
            OP_MIX_SUM:
            begin
                res_reg <= m_sum[39:16];
            end
            default:
            begin
            end
        endcase
    end

    assign status.drive_zero = (drive_reg == '0);
    assign status.div_busy   = div_busy;
    assign sample_out        = res_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/asc_ctrl.sv -----
`default_nettype none
// ============================================================================
// asc_ctrl
// Sequencer for drive updates and per-sample processing.
// ============================================================================
module asc_ctrl
    import asc_pkg::*;
#(
    parameter int CORDIC_STEPS = 20
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire logic    knob_wr,
    input  wire logic    out_free,
    input  wire status_t status,
    output cmd_t         cmd
);

    localparam int IT_W = $clog2(CORDIC_STEPS);

    state_t          state_reg, state_next;
    logic [IT_W-1:0] iter_reg, iter_next;
    logic            pend_reg, pend_next;
    logic            drv_mode_reg, drv_mode_next;
    logic            pend_clr;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            pend_reg     <= 1'b0;
            drv_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            iter_reg     <= iter_next;
            pend_reg     <= pend_next;
            drv_mode_reg <= drv_mode_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        drv_mode_next = drv_mode_reg;
        pend_clr      = 1'b0;
        s_tready      = 1'b0;
        cmd.op        = OP_NONE;
        cmd.iter      = ITER_W'(iter_reg);
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = !pend_reg;
                if (pend_reg)
                begin
                    pend_clr      = 1'b1;
                    drv_mode_next = 1'b1;
                    state_next    = ST_DRV_SQ;
                end
                else if (s_tvalid)
                begin
                    cmd.op        = OP_LOAD_X;
                    drv_mode_next = 1'b0;
                    state_next    = status.drive_zero ? ST_PASS : ST_SC_MUL;
                end
            end
            ST_DRV_SQ:
            begin
                cmd.op     = OP_DRV_SQ;
                state_next = ST_DRV_RND;
            end
            ST_DRV_RND:
            begin
                cmd.op     = OP_DRV_RND;
                iter_next  = '0;
                state_next = ST_CORDIC;
            end
            ST_SC_MUL:
            begin
                cmd.op     = OP_SC_MUL;
                state_next = ST_SC_Z;
            end
            ST_SC_Z:
            begin
                cmd.op     = OP_SC_Z;
                iter_next  = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                cmd.op = OP_COR_STEP;
                if (iter_reg == IT_W'(CORDIC_STEPS - 1))
                begin
                    iter_next  = '0;
                    state_next = ST_ATAN_DIV;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_ATAN_DIV:
            begin
                cmd.op     = OP_ATAN_DIV;
                state_next = ST_ATAN_WAIT;
            end
            ST_ATAN_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ATAN_RES;
                end
            end
            ST_ATAN_RES:
            begin
                cmd.op     = OP_ATAN_RES;
                state_next = drv_mode_reg ? ST_DRV_NORM : ST_SC_DIV;
            end
            ST_DRV_NORM:
            begin
                cmd.op     = OP_DRV_NORM;
                state_next = ST_IDLE;
            end
            ST_SC_DIV:
            begin
                cmd.op     = OP_SC_DIV;
                state_next = ST_SC_WAIT;
            end
            ST_SC_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_SC_RES;
                end
            end
            ST_SC_RES:
            begin
                cmd.op     = OP_SC_RES;
                state_next = ST_HP_LO;
            end
            ST_PASS:
            begin
                cmd.op     = OP_PASS;
                state_next = ST_HP_LO;
            end
            ST_HP_LO:
            begin
                cmd.op     = OP_HP_LO;
                state_next = ST_HP_HI;
            end
            ST_HP_HI:
            begin
                cmd.op     = OP_HP_HI;
                state_next = ST_HP_RND;
            end
            ST_HP_RND:
            begin
                cmd.op     = OP_HP_RND;
                state_next = ST_HP_W;
            end
            ST_HP_W:
            begin
                cmd.op     = OP_HP_W;
                state_next = ST_HP_D;
            end
            ST_HP_D:
            begin
                cmd.op     = OP_HP_D;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = ST_CLIP;
            end
            ST_CLIP:
            begin
                cmd.op     = OP_CLIP;
                state_next = ST_MIX_A;
            end
            ST_MIX_A:
            begin
                cmd.op     = OP_MIX_A;
                state_next = ST_MIX_B;
            end
            ST_MIX_B:
            begin
                cmd.op     = OP_MIX_B;
                state_next = ST_MIX_SUM;
            end
            ST_MIX_SUM:
            begin
                cmd.op     = OP_MIX_SUM;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A knob write always leaves a drive update pending.
    assign pend_next = knob_wr | (pend_reg & !pend_clr);

    // Checks.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while a sample is in flight");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded into an occupied output register");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ATAN_DIV || cmd.op == OP_SC_DIV) |-> !status.div_busy)
        else $error("divider restarted while busy");

    a_knob_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        knob_wr |=> !s_tready)
        else $error("sample accepted before the drive update");

endmodule
`default_nettype wire
